/* sv/indexed_insert_remove_array_unit_defines.svh */
// Assertion macros for the indexed insert/remove array unit.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef INDEXED_INSERT_REMOVE_ARRAY_UNIT_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IIRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define IIRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define IIRA_ASSERT_NOW(label, clk, rst, ante, cons)
`define IIRA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/iira_pkg.sv */
// Shared types and constants for the indexed insert/remove array unit.
// No dependencies; used by iira_cell and the top level.
package iira_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 4;
   localparam int MODE_W      = 2;
   localparam int FILL_W      = 5;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_DUMP   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_DUMP = 1'b1
   } fsm_type;

endpackage

/* sv/indexed_insert_remove_array_unit.sv */
// Top level of the indexed insert/remove array: cell row, control and output register.
// Depends on iira_pkg, iira_cell and indexed_insert_remove_array_unit_defines.svh.
//
//  channel | dir | tdata (low bit up)                          | tuser       | tlast
//  req     | in  | position[3:0], word_in[35:4], zero pad      | mode[1:0]   | -
//  rsp     | out | word_out[31:0], fill_count[36:32],          | word_valid  | last
//          |     | status[38:37], zero pad                     |             |
//
//  Push, insert and remove update the whole row at once: every cell picks its next word.
//  Dump enters the dump state, then sends one entry per cycle while rsp is ready, read
//  from cell 0 while the held entries rotate down the row back to their places.
//  A request is taken when the controller is idle and the output register is free or
//  draining; a stalled rsp channel holds the dump in place.
//  Synchronous active-high reset empties the array; cell words are not cleared.
`include "indexed_insert_remove_array_unit_defines.svh"

module indexed_insert_remove_array_unit #(
   parameter int DEPTH = iira_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // position, word_in, zero pad
   input  logic [iira_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode
   input  logic [iira_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // word_out, fill_count, status, zero pad
   output logic [iira_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // word_valid
   output logic [iira_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CMPW = (CW > iira_pkg::POS_W) ? CW : iira_pkg::POS_W;
   localparam int WW   = iira_pkg::WORD_W;
   localparam int PADW = iira_pkg::RSP_TDATA_W - WW - iira_pkg::FILL_W - iira_pkg::STATUS_W;

   iira_pkg::fsm_type      state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          dump_idx_ff, dump_idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [WW-1:0]   rsp_word_ff, rsp_word_in;
   logic                   rsp_wvalid_ff, rsp_wvalid_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;
   iira_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;

   iira_pkg::cell_op_type  cell_op;
   logic [CW-1:0]          cell_pos;

   iira_pkg::mode_type     req_mode;
   logic [iira_pkg::POS_W-1:0] req_pos;
   logic signed [WW-1:0]   req_word;
   logic                   req_accept;
   logic                   out_free;
   logic                   is_full;
   logic                   is_empty;
   logic [CW-1:0]          count_last;
   logic [CMPW-1:0]        pos_ext;
   logic [CMPW-1:0]        count_ext;
   logic [CW-1:0]          ins_pos;
   logic [CW-1:0]          rem_pos;
   logic                   dump_last;

   logic signed [WW-1:0]   cell_word [DEPTH];

   assign req_mode = iira_pkg::mode_type'(req_tuser[iira_pkg::MODE_W-1:0]);
   assign req_pos  = req_tdata[iira_pkg::POS_W-1:0];
   assign req_word = req_tdata[iira_pkg::POS_W +: WW];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == iira_pkg::FSM_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;

   assign is_full    = (count_ff == CW'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign count_last = count_ff - CW'(1);
   assign pos_ext    = CMPW'(req_pos);
   assign count_ext  = CMPW'(count_ff);
   assign ins_pos    = ((req_mode == iira_pkg::MODE_PUSH) || (pos_ext > count_ext)) ?
                       count_ff : CW'(pos_ext);
   assign rem_pos    = (pos_ext >= count_ext) ? count_last : CW'(pos_ext);
   assign dump_last  = (CW'(dump_idx_ff) == count_last);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_word_in   = rsp_word_ff;
      rsp_wvalid_in = rsp_wvalid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      cell_op       = iira_pkg::CELL_HOLD;
      cell_pos      = ins_pos;

      case (state_ff)
         iira_pkg::FSM_IDLE: begin
            if (req_accept) begin
               rsp_word_in   = '0;
               rsp_wvalid_in = 1'b0;
               rsp_status_in = iira_pkg::STAT_OK;
               rsp_last_in   = 1'b1;
               rsp_count_in  = count_ff;
               rsp_valid_in  = 1'b1;
               case (req_mode)
                  iira_pkg::MODE_PUSH, iira_pkg::MODE_INSERT: begin
                     if (is_full) begin
                        rsp_status_in = iira_pkg::STAT_FULL;
                     end else begin
                        cell_op      = iira_pkg::CELL_INSERT;
                        cell_pos     = ins_pos;
                        count_in     = count_ff + CW'(1);
                        rsp_count_in = count_ff + CW'(1);
                     end
                  end
                  iira_pkg::MODE_REMOVE: begin
                     if (is_empty) begin
                        rsp_status_in = iira_pkg::STAT_EMPTY;
                     end else begin
                        cell_op      = iira_pkg::CELL_REMOVE;
                        cell_pos     = rem_pos;
                        count_in     = count_last;
                        rsp_count_in = count_last;
                     end
                  end
                  default: begin
                     if (!is_empty) begin
                        rsp_valid_in = 1'b0;
                        dump_idx_in  = '0;
                        state_in     = iira_pkg::FSM_DUMP;
                     end
                  end
               endcase
            end
         end
         iira_pkg::FSM_DUMP: begin
            if (out_free) begin
               cell_op       = iira_pkg::CELL_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_word_in   = cell_word[0];
               rsp_wvalid_in = 1'b1;
               rsp_count_in  = count_ff;
               rsp_status_in = iira_pkg::STAT_OK;
               rsp_last_in   = dump_last;
               dump_idx_in   = dump_idx_ff + IW'(1);
               if (dump_last) begin
                  state_in = iira_pkg::FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = iira_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iira_pkg::FSM_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff   <= rsp_word_in;
      rsp_wvalid_ff <= rsp_wvalid_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int Prev = (i == 0) ? 0 : i - 1;
      localparam int Next = (i == DEPTH - 1) ? i : i + 1;
      iira_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock     (clock),
         .op        (cell_op),
         .pos       (cell_pos),
         .count     (count_ff),
         .prev_word (cell_word[Prev]),
         .next_word (cell_word[Next]),
         .head_word (cell_word[0]),
         .load_word (req_word),
         .word      (cell_word[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PADW{1'b0}}, rsp_status_ff,
                        iira_pkg::FILL_W'(rsp_count_ff), rsp_word_ff};
   assign rsp_tuser  = rsp_wvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

   `IIRA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `IIRA_ASSERT_NOW(a_dump_idx_bound, clock, reset, state_ff == iira_pkg::FSM_DUMP,
                    CW'(dump_idx_ff) < count_ff)
   `IIRA_ASSERT_NOW(a_full_status, clock, reset,
                    rsp_valid_ff && (rsp_status_ff == iira_pkg::STAT_FULL),
                    rsp_count_ff == CW'(DEPTH))
   `IIRA_ASSERT_NEXT(a_grow, clock, reset,
                     req_accept && !is_full && ((req_mode == iira_pkg::MODE_PUSH) ||
                     (req_mode == iira_pkg::MODE_INSERT)),
                     count_ff == $past(count_ff) + CW'(1))
   `IIRA_ASSERT_NEXT(a_shrink, clock, reset,
                     req_accept && !is_empty && (req_mode == iira_pkg::MODE_REMOVE),
                     count_ff == $past(count_ff) - CW'(1))

endmodule

/* sv/iira_cell.sv */
// One storage cell of the array: holds a word and picks hold, load, a neighbor or the head word.
// Depends on iira_pkg.
module iira_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                                clock,
   input  iira_pkg::cell_op_type               op,
   input  logic [CW-1:0]                       pos,
   input  logic [CW-1:0]                       count,
   input  logic signed [iira_pkg::WORD_W-1:0]  prev_word,
   input  logic signed [iira_pkg::WORD_W-1:0]  next_word,
   input  logic signed [iira_pkg::WORD_W-1:0]  head_word,
   input  logic signed [iira_pkg::WORD_W-1:0]  load_word,
   output logic signed [iira_pkg::WORD_W-1:0]  word
);

   localparam logic [CW-1:0] Idx = CW'(INDEX);

   logic signed [iira_pkg::WORD_W-1:0] word_ff;
   logic signed [iira_pkg::WORD_W-1:0] word_in;
   logic [CW-1:0]                      last_idx;

   assign last_idx = count - CW'(1);

   always_comb begin
      word_in = word_ff;
      case (op)
         iira_pkg::CELL_INSERT: begin
            if (Idx == pos) begin
               word_in = load_word;
            end else if ((Idx > pos) && (Idx <= count)) begin
               word_in = prev_word;
            end
         end
         iira_pkg::CELL_REMOVE: begin
            if ((Idx >= pos) && (Idx < last_idx)) begin
               word_in = next_word;
            end
         end
         iira_pkg::CELL_ROTATE: begin
            if (Idx == last_idx) begin
               word_in = head_word;
            end else if (Idx < last_idx) begin
               word_in = next_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule
